@@ src/rfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Record frame decoder package
// Shared types, constants and the CRC-16/CCITT-FALSE byte update.
// ---------------------------------------------------------------------------
package rfd_pkg;

  localparam int CntW = 5;
  localparam logic [CntW-1:0] RecordBytes = 5'd20;
  localparam logic [CntW-1:0] CheckOffset = 5'd18;
  localparam int HdrDepth = 18;

  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] CrcStart = 16'hFFFF;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_VERSION = 2'd2;
  localparam logic [1:0] ST_BAD_CRC = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  record_version;
    logic [7:0]  reading_type;
    logic [7:0]  quality;
    logic [7:0]  flags;
    logic [31:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] value_bits;
    logic [15:0] boot_number;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/record_frame_decoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Record frame decoder top level
// Checks 20-byte records with CRC-16/CCITT-FALSE and unpacks their fields.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    in_data_byte, in_last_byte
//   out      out_valid/out_ready  out_status and the unpacked record fields
//   cfg      cfg_wr_en            cfg_wr_data (expected version)
//
// One request is taken per cycle while no final byte stalls; an accepted
// final byte's result passes the input register, then the result register.
// Reset is synchronous: it clears the byte count, sets the CRC to its start
// value and the expected version to one. A waiting result stalls only a
// final byte; other bytes keep flowing while the output register is full.
// ---------------------------------------------------------------------------
module record_frame_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_record_version,
  output logic [7:0]       out_reading_type,
  output logic [7:0]       out_quality,
  output logic [7:0]       out_flags,
  output logic [31:0]      out_sequence_res,
  output logic [31:0]      out_timestamp,
  output logic [31:0]      out_value_bits,
  output logic [15:0]      out_boot_number,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);
  import rfd_pkg::*;

  logic [7:0] expected_version_r;
  byte_req_t  in_req;
  byte_req_t  s1_req;
  logic       s1_valid;
  logic       s1_adv;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_version_r <= 8'd1;
    end else if (cfg_wr_en) begin
      expected_version_r <= cfg_wr_data;
    end
  end

  assign in_req.data_byte = in_data_byte;
  assign in_req.last_byte = in_last_byte;

  assign s1_adv = s1_valid && (!s1_req.last_byte || !out_valid || out_ready);

  rfd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .adv      (s1_adv),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  rfd_frame_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (s1_adv),
    .req              (s1_req),
    .expected_version (expected_version_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  rfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_status         = out_res.status;
  assign out_record_version = out_res.record_version;
  assign out_reading_type   = out_res.reading_type;
  assign out_quality        = out_res.quality;
  assign out_flags          = out_res.flags;
  assign out_sequence_res   = out_res.sequence_res;
  assign out_timestamp      = out_res.timestamp;
  assign out_value_bits     = out_res.value_bits;
  assign out_boot_number    = out_res.boot_number;

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !in_ready) |-> (out_valid && !out_ready && s1_req.last_byte))
    else $error("input stalled without a blocked final byte");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_record_version == 8'd0 && out_sequence_res == 32'd0 &&
       out_timestamp == 32'd0 && out_value_bits == 32'd0 && out_boot_number == 16'd0))
    else $error("error result carries nonzero fields");

endmodule
`default_nettype wire

@@ src/rfd_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Record frame decoder input register
// Captures one request and holds it until the frame logic consumes it.
// ---------------------------------------------------------------------------
module rfd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rfd_pkg::byte_req_t in_req,
  input  wire logic              adv,
  output logic                   s1_valid,
  output rfd_pkg::byte_req_t     s1_req
);
  import rfd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  byte_req_t req_r;
  logic      take;

  assign in_ready = !valid_r || adv;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_req;
    end
  end

  assign s1_valid = valid_r;
  assign s1_req   = req_r;

endmodule
`default_nettype wire

@@ src/rfd_frame_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Record frame decoder core
// Tracks the byte count, running CRC, stored header and check, and forms
// the result on the final byte of a buffer.
// ---------------------------------------------------------------------------
module rfd_frame_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire rfd_pkg::byte_req_t req,
  input  wire logic [7:0]         expected_version,
  output logic                    res_valid,
  output rfd_pkg::result_t        res
);
  import rfd_pkg::*;

  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic [15:0]     crc_r;
  logic [15:0]     crc_nxt;
  logic [7:0]      hdr_r [0:HdrDepth-1];
  logic [15:0]     check_r;
  logic [15:0]     check_now;
  logic [1:0]      status;

  assign check_now = (count_r == CheckOffset + 5'd1) ? {req.data_byte, check_r[7:0]} : check_r;

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    if (fire) begin
      if (count_r < CheckOffset) begin
        crc_nxt = crc_byte(crc_r, req.data_byte);
      end
      if (count_r < RecordBytes) begin
        count_nxt = count_r + 5'd1;
      end
      if (req.last_byte) begin
        count_nxt = '0;
        crc_nxt   = CrcStart;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CrcStart;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && count_r < CheckOffset) begin
      hdr_r[count_r] <= req.data_byte;
    end
    if (fire && count_r == CheckOffset) begin
      check_r[7:0] <= req.data_byte;
    end
    if (fire && count_r == CheckOffset + 5'd1) begin
      check_r[15:8] <= req.data_byte;
    end
  end

  always_comb begin
    if (count_r < CheckOffset + 5'd1) begin
      status = ST_SHORT;
    end else if (hdr_r[0] != expected_version) begin
      status = ST_VERSION;
    end else if (crc_r != check_now) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.record_version = hdr_r[0];
      res.reading_type   = hdr_r[1];
      res.quality        = hdr_r[2];
      res.flags          = hdr_r[3];
      res.sequence_res   = {hdr_r[7], hdr_r[6], hdr_r[5], hdr_r[4]};
      res.timestamp      = {hdr_r[11], hdr_r[10], hdr_r[9], hdr_r[8]};
      res.value_bits     = {hdr_r[15], hdr_r[14], hdr_r[13], hdr_r[12]};
      res.boot_number    = {hdr_r[17], hdr_r[16]};
    end
  end

  assign res_valid = fire && req.last_byte;

endmodule
`default_nettype wire

@@ src/rfd_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Record frame decoder output register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module rfd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire rfd_pkg::result_t res,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output rfd_pkg::result_t      out_res
);
  import rfd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire
